/* design/ibcfd_pkg.sv */
// Package for the iBus channel frame decoder.
// Holds the frame constants, the sequencer state type and the checksum control struct.
// No dependencies.
package ibcfd_pkg;

  localparam int unsigned FrameLen  = 32;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned ChanIdxW  = 4;

  localparam logic [7:0]  LenByte   = 8'd32;
  localparam logic [7:0]  CmdByte   = 8'h40;
  localparam logic [15:0] CheckBase = 16'hFFFF;

  // Frame positions with a role of their own
  localparam logic [AddrW-1:0] PosCmd     = 5'd1;
  localparam logic [AddrW-1:0] PosCheckLo = 5'd30;
  localparam logic [AddrW-1:0] PosCheckHi = 5'd31;
  localparam logic [AddrW-1:0] PosChan0   = 5'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RECV,
    S_CHECK,
    S_RD_LO,
    S_RD_HI,
    S_RD_WAIT,
    S_EMIT
  } state_t;

  // Control of the checksum accumulator
  typedef struct packed {
    logic load;     // start a new sum with the length byte
    logic add;      // add a covered byte
    logic keep_lo;  // capture checksum low byte
    logic keep_hi;  // capture checksum high byte
  } acc_ctl_t;

endpackage

/* design/ibcfd_if.sv */
// Stream interfaces of the iBus channel frame decoder: received bytes in, channel results out.
// Depends on ibcfd_pkg for the index width.
interface ibcfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ibcfd_res_if;
  logic                             valid;
  logic                             ready;
  logic [ibcfd_pkg::ChanIdxW-1:0]   channel_index;
  logic [15:0]                      channel_value;
  logic                             last_of_frame;
  logic [31:0]                      frames_received;

  modport source (output valid, output channel_index, output channel_value,
                  output last_of_frame, output frames_received, input ready);
  modport sink   (input valid, input channel_index, input channel_value,
                  input last_of_frame, input frames_received, output ready);
endinterface

/* design/ibus_channel_frame_decoder.sv */
// iBus channel frame decoder top level: byte sequencer, frame store and channel emitter.
// Depends on ibcfd_pkg, ibcfd_if, ibcfd_ram and ibcfd_accum.
//
// Takes one received byte per transfer and finds 32-byte iBus channel frames: a length
// byte of 32, a command byte of 0x40, 28 channel bytes and a little-endian checksum.
// While a frame comes in, a byte is taken every cycle and the checksum sum is built as
// it arrives. After the last byte the block stops taking bytes in the check state; a
// good frame then yields NUM_CHANNELS results, each made by two reads of the single
// frame-store read port (low byte, then high byte), a wait state for the registered read
// data and the output register, which holds while the sink is not ready. The input stays
// stalled until the last result of a good frame is taken, or through the check state of a
// bad frame. Bad frames are dropped with no result. The frame store needs no clearing after reset.
module ibus_channel_frame_decoder #(
  parameter int unsigned NUM_CHANNELS = 14
) (
  input  logic        clk,
  input  logic        rst,
  ibcfd_rx_if.sink    rx_ch,
  ibcfd_res_if.source res_ch
);

  localparam int unsigned AW = ibcfd_pkg::AddrW;
  localparam int unsigned CW = ibcfd_pkg::ChanIdxW;
  localparam logic [CW-1:0] LastChan = CW'(NUM_CHANNELS - 1);

  ibcfd_pkg::state_t   state;
  ibcfd_pkg::state_t   state_next;
  ibcfd_pkg::acc_ctl_t acc_ctl;

  logic [AW-1:0] pos;
  logic [CW-1:0] ch;
  logic [7:0]    lo_byte;
  logic [31:0]   frame_count;

  logic [CW-1:0] out_index;
  logic [15:0]   out_value;
  logic          out_last;
  logic [31:0]   out_count;

  logic          rx_fire;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] chan_addr;
  logic [7:0]    rd_data;
  logic          match;
  logic          is_len;
  logic          is_cmd;

  assign rx_fire   = rx_ch.valid && rx_ch.ready;
  assign is_len    = (rx_ch.rx_byte == ibcfd_pkg::LenByte);
  assign is_cmd    = (rx_ch.rx_byte == ibcfd_pkg::CmdByte);
  assign chan_addr = {ch, 1'b0} + ibcfd_pkg::PosChan0;

  ibcfd_ram #(
    .WIDTH (8),
    .DEPTH (ibcfd_pkg::FrameLen)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (rx_ch.rx_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ibcfd_accum u_accum (
    .clk   (clk),
    .ctl   (acc_ctl),
    .data  (rx_ch.rx_byte),
    .match (match)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ibcfd_pkg::S_IDLE: begin
        if (rx_fire && is_len) state_next = ibcfd_pkg::S_RECV;
      end
      ibcfd_pkg::S_RECV: begin
        if (rx_fire) begin
          if (pos == ibcfd_pkg::PosCmd && !is_cmd) begin
            state_next = ibcfd_pkg::S_IDLE;
          end else if (pos == ibcfd_pkg::PosCheckHi) begin
            state_next = ibcfd_pkg::S_CHECK;
          end
        end
      end
      ibcfd_pkg::S_CHECK:   state_next = match ? ibcfd_pkg::S_RD_LO : ibcfd_pkg::S_IDLE;
      ibcfd_pkg::S_RD_LO:   state_next = ibcfd_pkg::S_RD_HI;
      ibcfd_pkg::S_RD_HI:   state_next = ibcfd_pkg::S_RD_WAIT;
      ibcfd_pkg::S_RD_WAIT: state_next = ibcfd_pkg::S_EMIT;
      ibcfd_pkg::S_EMIT: begin
        if (res_ch.ready) begin
          state_next = out_last ? ibcfd_pkg::S_IDLE : ibcfd_pkg::S_RD_LO;
        end
      end
      default: state_next = ibcfd_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer; ready is high in both receive states, so valid alone
  // marks a transfer there
  always_comb begin
    rx_ch.ready     = 1'b0;
    res_ch.valid    = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = pos;
    rd_addr         = chan_addr;
    acc_ctl         = '0;
    unique case (state)
      ibcfd_pkg::S_IDLE: begin
        rx_ch.ready  = 1'b1;
        wr_addr      = '0;
        wr_en        = rx_ch.valid && is_len;
        acc_ctl.load = rx_ch.valid && is_len;
      end
      ibcfd_pkg::S_RECV: begin
        rx_ch.ready     = 1'b1;
        wr_en           = rx_ch.valid;
        acc_ctl.add     = rx_ch.valid && (pos < ibcfd_pkg::PosCheckLo);
        acc_ctl.keep_lo = rx_ch.valid && (pos == ibcfd_pkg::PosCheckLo);
        acc_ctl.keep_hi = rx_ch.valid && (pos == ibcfd_pkg::PosCheckHi);
      end
      ibcfd_pkg::S_RD_HI: rd_addr = chan_addr + AW'(1);
      ibcfd_pkg::S_EMIT:  res_ch.valid = 1'b1;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ibcfd_pkg::S_IDLE;
      pos         <= '0;
      ch          <= '0;
      frame_count <= '0;
    end else begin
      state <= state_next;
      // Advance the byte position, rewind it whenever a frame ends
      if (state_next == ibcfd_pkg::S_RECV) begin
        if (rx_fire) pos <= pos + AW'(1);
      end else begin
        pos <= '0;
      end
      // Count good frames, walk the channels
      if (state == ibcfd_pkg::S_CHECK && match) begin
        frame_count <= frame_count + 32'd1;
        ch          <= '0;
      end else if (state == ibcfd_pkg::S_EMIT && res_ch.ready) begin
        ch <= ch + CW'(1);
      end
    end
  end

  // Channel assembly and output register
  always_ff @(posedge clk) begin
    if (state == ibcfd_pkg::S_RD_HI) begin
      lo_byte <= rd_data;
    end
    if (state == ibcfd_pkg::S_RD_WAIT) begin
      out_index <= ch;
      out_value <= {rd_data, lo_byte};
      out_last  <= (ch == LastChan);
      out_count <= frame_count;
    end
  end

  assign res_ch.channel_index   = out_index;
  assign res_ch.channel_value   = out_value;
  assign res_ch.last_of_frame   = out_last;
  assign res_ch.frames_received = out_count;

endmodule

/* design/ibcfd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ibcfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/ibcfd_accum.sv */
// Checksum accumulator: one shared 16-bit adder summing frame bytes as they arrive.
// Depends on ibcfd_pkg for the control struct and the checksum base.
module ibcfd_accum (
  input  logic                clk,
  input  ibcfd_pkg::acc_ctl_t ctl,
  input  logic [7:0]          data,
  output logic                match
);

  logic [15:0] sum;
  logic [7:0]  check_lo;
  logic [7:0]  check_hi;

  // Accumulate covered bytes, hold the received checksum
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sum <= {8'd0, data};
    end else if (ctl.add) begin
      sum <= sum + {8'd0, data};
    end
    if (ctl.keep_lo) begin
      check_lo <= data;
    end
    if (ctl.keep_hi) begin
      check_hi <= data;
    end
  end

  // Compare the computed checksum with the received little-endian word
  assign match = ((ibcfd_pkg::CheckBase - sum) == {check_hi, check_lo});

endmodule

/* design/ibcfd_checker.sv */
// Port-level checker for the iBus channel frame decoder, bound to the top level.
// Depends on ibcfd_pkg for the index width.
module ibcfd_checker #(
  parameter int unsigned NUM_CHANNELS = 14
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           rx_ready,
  input logic                           res_valid,
  input logic                           res_ready,
  input logic [ibcfd_pkg::ChanIdxW-1:0] channel_index,
  input logic [15:0]                    channel_value,
  input logic                           last_of_frame,
  input logic [31:0]                    frames_received
);

  localparam logic [ibcfd_pkg::ChanIdxW-1:0] LastChan =
    ibcfd_pkg::ChanIdxW'(NUM_CHANNELS - 1);

  // Bytes are never taken while a result is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !rx_ready)
    else $error("input ready while a result is pending");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(channel_index) &&
      $stable(channel_value) && $stable(last_of_frame) && $stable(frames_received))
    else $error("stalled result changed");

  // The marked result is the last channel
  a_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && last_of_frame |-> channel_index == LastChan)
    else $error("last_of_frame on wrong channel");

  // Frame count holds between channels of one frame
  a_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !last_of_frame |=> $stable(frames_received))
    else $error("frame count changed inside a frame");

endmodule

bind ibus_channel_frame_decoder ibcfd_checker #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_ibcfd_checker (
  .clk             (clk),
  .rst             (rst),
  .rx_ready        (rx_ch.ready),
  .res_valid       (res_ch.valid),
  .res_ready       (res_ch.ready),
  .channel_index   (res_ch.channel_index),
  .channel_value   (res_ch.channel_value),
  .last_of_frame   (res_ch.last_of_frame),
  .frames_received (res_ch.frames_received)
);

/* tb/ibus_channel_frame_decoder_tb.sv */
// Testbench for the iBus channel frame decoder: drives framed byte streams with noise,
// bad commands and corrupted frames, and checks every channel result against a predictor.
// Depends on ibcfd_pkg, ibcfd_if and the ibus_channel_frame_decoder RTL.
module ibus_channel_frame_decoder_tb;

  localparam int NumChannels = 14;
  localparam int StimItems   = 410;
  localparam int CycleLimit  = 300000;
  localparam int DrainCycles = 80;

  typedef struct {
    logic [ibcfd_pkg::ChanIdxW-1:0] idx;
    logic [15:0]                    value;
    logic                           last;
    logic [31:0]                    count;
  } chan_result_t;

  typedef enum {FK_GOOD, FK_BAD_SUM, FK_BAD_BODY, FK_EXTREME} frame_kind_t;
  typedef enum {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_RUNS} sink_mode_t;

  // Predicts channel results from accepted bytes and checks them in order
  class frame_scoreboard;
    logic [5:0]   byte_pos;
    logic [7:0]   frame_bytes [ibcfd_pkg::FrameLen];
    logic [15:0]  chan_regs [NumChannels];
    logic [31:0]  good_frames;
    chan_result_t expected_q [$];
    int           errors;
    int           results_checked;

    function new();
      byte_pos = '0;
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
      foreach (chan_regs[i]) chan_regs[i] = '0;
      good_frames = '0;
      errors = 0;
      results_checked = 0;
    endfunction

    function void note_byte(logic [7:0] b);
      logic [15:0]  calc;
      logic [15:0]  got;
      logic [4:0]   off;
      chan_result_t r;
      // idle: only a length byte opens a frame
      if (byte_pos == 6'd0) begin
        if (b == ibcfd_pkg::LenByte) begin
          frame_bytes[0] = b;
          byte_pos = 6'd1;
        end
        return;
      end
      frame_bytes[byte_pos[4:0]] = b;
      byte_pos = byte_pos + 6'd1;
      // drop on a wrong command byte, without retesting it as a header
      if (byte_pos == 6'd2 && b != ibcfd_pkg::CmdByte) begin
        byte_pos = 6'd0;
        return;
      end
      if (byte_pos >= ibcfd_pkg::FrameLen) begin
        byte_pos = 6'd0;
        calc = ibcfd_pkg::CheckBase;
        for (int i = 0; i < int'(ibcfd_pkg::PosCheckLo); i++) begin
          calc = calc - {8'h00, frame_bytes[i]};
        end
        got = {frame_bytes[ibcfd_pkg::PosCheckHi], frame_bytes[ibcfd_pkg::PosCheckLo]};
        if (got == calc) begin
          good_frames = good_frames + 32'd1;
          for (int ch = 0; ch < NumChannels; ch++) begin
            off = 5'(int'(ibcfd_pkg::PosChan0) + 2 * ch);
            chan_regs[ch] = {frame_bytes[off + 5'd1], frame_bytes[off]};
            r.idx   = ibcfd_pkg::ChanIdxW'(ch);
            r.value = chan_regs[ch];
            r.last  = (ch == NumChannels - 1);
            r.count = good_frames;
            expected_q.push_back(r);
          end
        end
      end
    endfunction

    function void check_result(logic [ibcfd_pkg::ChanIdxW-1:0] idx, logic [15:0] value,
                               logic last, logic [31:0] count);
      chan_result_t e;
      results_checked++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result ch %0d value %h last %0b count %0d",
                 $time, idx, value, last, count);
        return;
      end
      e = expected_q.pop_front();
      if (idx !== e.idx || value !== e.value || last !== e.last || count !== e.count) begin
        errors++;
        $display("%0t: result mismatch: expected ch %0d value %h last %0b count %0d",
                 $time, e.idx, e.value, e.last, e.count);
        $display("%0t:                      got ch %0d value %h last %0b count %0d",
                 $time, idx, value, last, count);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  ibcfd_rx_if  rx_if();
  ibcfd_res_if res_if();

  ibus_channel_frame_decoder #(
    .NUM_CHANNELS(NumChannels)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .rx_ch  (rx_if),
    .res_ch (res_if)
  );

  frame_scoreboard sb;
  int          cycle_count;
  int          burst_left;
  int          transfers_in;
  int          counted_items;
  sink_mode_t  sink_mode;
  int          sink_mode_left;
  int          run_left;
  logic        run_level;

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d results still owed",
               $time, cycle_count, sb.pending());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Check each result transfer and stall the result side on a changing pattern
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        sb.check_result(res_if.channel_index, res_if.channel_value, res_if.last_of_frame,
                        res_if.frames_received);
      end
      if (sink_mode_left <= 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 3));
        sink_mode_left = $urandom_range(20, 200);
      end
      sink_mode_left--;
      case (sink_mode)
        SINK_OPEN: begin
          res_if.ready <= 1'b1;
        end
        SINK_LIGHT: begin
          res_if.ready <= ($urandom_range(0, 9) < 8);
        end
        SINK_HEAVY: begin
          res_if.ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          if (run_left <= 0) begin
            run_level = ~run_level;
            run_left = $urandom_range(1, 20);
          end
          run_left--;
          res_if.ready <= run_level;
        end
      endcase
    end
  end

  function automatic int next_burst();
    if ($urandom_range(0, 7) == 0) return $urandom_range(100, 300);
    return $urandom_range(1, 40);
  endfunction

  function automatic logic [15:0] pick_channel_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    if (r < 6) return 16'($urandom_range(1000, 2000));
    return 16'($urandom);
  endfunction

  // Offer one byte, hold it until transferred, then idle between bursts
  task automatic send_byte(input logic [7:0] b);
    int gap;
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    sb.note_byte(b);
    transfers_in++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = next_burst();
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 8);
      if (gap > 0) begin
        rx_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Build a 32-byte frame with a valid checksum, then corrupt it as asked
  task automatic send_frame(input frame_kind_t kind);
    logic [7:0]  fb [ibcfd_pkg::FrameLen];
    logic [15:0] v;
    logic [15:0] sum;
    fb[0] = ibcfd_pkg::LenByte;
    fb[ibcfd_pkg::PosCmd] = ibcfd_pkg::CmdByte;
    for (int ch = 0; ch < NumChannels; ch++) begin
      if (kind == FK_EXTREME) v = (ch % 2 == 0) ? 16'h0000 : 16'hFFFF;
      else v = pick_channel_value();
      fb[int'(ibcfd_pkg::PosChan0) + 2 * ch]     = v[7:0];
      fb[int'(ibcfd_pkg::PosChan0) + 2 * ch + 1] = v[15:8];
    end
    sum = ibcfd_pkg::CheckBase;
    for (int i = 0; i < int'(ibcfd_pkg::PosCheckLo); i++) sum = sum - {8'h00, fb[i]};
    fb[ibcfd_pkg::PosCheckLo] = sum[7:0];
    fb[ibcfd_pkg::PosCheckHi] = sum[15:8];
    if (kind == FK_BAD_SUM) begin
      fb[$urandom_range(int'(ibcfd_pkg::PosCheckLo), int'(ibcfd_pkg::PosCheckHi))] ^=
        8'(1 << $urandom_range(0, 7));
    end else if (kind == FK_BAD_BODY) begin
      fb[$urandom_range(int'(ibcfd_pkg::PosChan0), int'(ibcfd_pkg::PosCheckLo) - 1)] ^=
        8'(1 << $urandom_range(0, 7));
    end
    for (int i = 0; i < int'(ibcfd_pkg::FrameLen); i++) send_byte(fb[i]);
    counted_items += ibcfd_pkg::FrameLen;
  endtask

  // Open a frame with a command byte other than the channel command
  task automatic send_bad_command();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == ibcfd_pkg::CmdByte) c = c ^ 8'(1 << $urandom_range(0, 7));
    send_byte(ibcfd_pkg::LenByte);
    send_byte(c);
    counted_items += 2;
  endtask

  initial begin
    int pick;
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = '0;
    res_if.ready = 1'b0;
    cycle_count = 0;
    transfers_in = 0;
    counted_items = 0;
    burst_left = next_burst();
    sink_mode = SINK_OPEN;
    sink_mode_left = 0;
    run_left = 0;
    run_level = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Idle bytes other than the length byte are ignored
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ibcfd_pkg::LenByte - 8'd1);
    send_byte(ibcfd_pkg::LenByte + 8'd1);
    // Wrong command byte drops the frame
    send_byte(ibcfd_pkg::LenByte);
    send_byte(8'h00);
    // A length byte in the command slot is not taken as a new header
    send_byte(ibcfd_pkg::LenByte);
    send_byte(ibcfd_pkg::LenByte);
    send_byte(ibcfd_pkg::CmdByte);
    // Channel values at both extremes
    send_frame(FK_EXTREME);
    counted_items = 0;

    // Mostly well-formed frames, with corrupted frames, bad commands and noise mixed in
    while (counted_items < StimItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_frame(FK_GOOD);
      end else if (pick < 75) begin
        send_frame(FK_BAD_SUM);
      end else if (pick < 82) begin
        send_frame(FK_BAD_BODY);
      end else if (pick < 92) begin
        send_bad_command();
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
    end
    rx_if.valid <= 1'b0;

    // Drain, then watch for stray results
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d byte transfers and %0d good frames; %0d channel results checked",
             transfers_in, sb.good_frames, sb.results_checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatched or unexpected results, %0d results never seen",
               sb.errors, sb.pending());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
